>>> hdl/klsa_pkg.sv
// ----------------------------------------------------------------------------
// klsa_pkg
// Shared types and constants of the keyed light slot allocator.
// ----------------------------------------------------------------------------
package klsa_pkg;

  localparam int KEY_W     = 16;
  localparam int TIME_W    = 32;
  localparam int DELTA_W   = 16;
  localparam int RAD_W     = 16;
  localparam int DECAY_W   = 16;
  localparam int SLOT_W    = 7;
  localparam int HOW_W     = 2;
  localparam int SLOTS_DEF = 128;

  // Item kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [HOW_W-1:0] {
    HOW_KEY     = 2'd0,
    HOW_EXPIRED = 2'd1,
    HOW_FORCED  = 2'd2,
    HOW_TICK    = 2'd3
  } how_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  expiry;
    logic [RAD_W-1:0]   radius;
    logic [DECAY_W-1:0] decay;
  } slot_rec_t;

endpackage

>>> hdl/klsa_in_if.sv
// ----------------------------------------------------------------------------
// klsa_in_if
// Request channel of the slot allocator: allocate or tick items.
// ----------------------------------------------------------------------------
interface klsa_in_if;
  import klsa_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [KEY_W-1:0]   light_key;
  logic [TIME_W-1:0]  now;
  logic [DELTA_W-1:0] elapsed;
  logic [RAD_W-1:0]   new_radius;
  logic [TIME_W-1:0]  new_expiry;
  logic [DECAY_W-1:0] new_decay;

  modport source (
    output valid, action, light_key, now, elapsed, new_radius, new_expiry, new_decay,
    input  ready
  );

  modport sink (
    input  valid, action, light_key, now, elapsed, new_radius, new_expiry, new_decay,
    output ready
  );

endinterface

>>> hdl/klsa_out_if.sv
// ----------------------------------------------------------------------------
// klsa_out_if
// Result channel of the slot allocator: chosen slot and how it was chosen.
// ----------------------------------------------------------------------------
interface klsa_out_if;
  import klsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic [HOW_W-1:0]  how_chosen;

  modport source (
    output valid, slot, how_chosen,
    input  ready
  );

  modport sink (
    input  valid, slot, how_chosen,
    output ready
  );

endinterface

>>> hdl/klsa_slot_table.sv
// ----------------------------------------------------------------------------
// klsa_slot_table
// Slot record memory, one read and one write port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module klsa_slot_table #(
  parameter int SLOTS = klsa_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output klsa_pkg::slot_rec_t      rd_rec,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  klsa_pkg::slot_rec_t      wr_rec
);
  import klsa_pkg::*;

  slot_rec_t        mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  slot_rec_t        rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written reads as its reset value, all zero
  assign rd_rec = rd_vld_r ? rd_data_r : '0;

endmodule

>>> hdl/keyed_light_slot_allocator.sv
// ----------------------------------------------------------------------------
// keyed_light_slot_allocator
// Keyed light slot table with expiry-based reuse and radius decay ticks.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  carries one item per transfer: an allocate (action 0) or a
//            decay tick (action 1) together with its time and slot fields.
//   out_chan returns exactly one result per item: the chosen slot and how
//            it was chosen, or slot 0 with "tick done" for a tick.
//   Every item walks the whole slot table, one slot per cycle, through one
//   memory read port. The result is registered in the finish state, once the
//   compare stage and, for a tick, the write-back stage have drained; ready
//   returns together with it. A tick runs each slot through one shared
//   16x16 multiplier and writes the shrunk radius back behind the read.
//   in_chan.ready is high only while the block holds no item in work.
//   The result sits in an output register; the next item can be accepted
//   while it waits, but its own result is held until the receiver takes
//   the previous one.
//   Reset (synchronous, rst_n low) clears all slots to zero at once and
//   drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_light_slot_allocator #(
  parameter int SLOTS = klsa_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  klsa_in_if.sink        in_chan,
  klsa_out_if.source     out_chan
);
  import klsa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_t state_r, state_nxt;

  // Captured item
  logic               act_r;
  logic [KEY_W-1:0]   key_r;
  logic [TIME_W-1:0]  now_r;
  logic [DELTA_W-1:0] elapsed_r;
  slot_rec_t          new_rec_r;

  // Scan and pipeline
  logic [IW-1:0]  rd_idx_r;
  logic           p1_v_r;
  logic [IW-1:0]  p1_idx_r;
  logic           p2_v_r;
  logic [IW-1:0]  p2_idx_r;
  slot_rec_t      p2_rec_r;
  logic           p2_live_r;
  logic [2*DELTA_W-1:0] p2_prod_r;

  // Allocation search results
  logic          found_key_r;
  logic [IW-1:0] key_idx_r;
  logic          found_exp_r;
  logic [IW-1:0] exp_idx_r;

  // Result register
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  how_t              out_how_r;

  // Control
  logic      in_xfer;
  logic      out_free;
  logic      rd_en;
  logic      finish_go;
  slot_rec_t rd_rec;
  logic      wr_en;
  logic [IW-1:0] wr_addr;
  slot_rec_t wr_rec;

  // Stage 1 and stage 2 datapath
  logic                 p1_key_hit;
  logic                 p1_expired;
  logic                 p1_live;
  logic [2*DELTA_W:0]   loss_sum;
  logic [DELTA_W:0]     loss;
  logic [RAD_W-1:0]     radius_dec;
  logic                 tick_wr;
  logic [IW-1:0]        pick_idx;
  how_t                 pick_how;

  klsa_slot_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_rec  (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_rec  (wr_rec)
  );

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_xfer  = in_chan.valid && in_chan.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_idx_r == LAST_IDX) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_chan.ready = 1'b0;
    rd_en         = 1'b0;
    finish_go     = 1'b0;
    case (state_r)
      ST_IDLE:   in_chan.ready = 1'b1;
      ST_SCAN:   rd_en         = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: finish_go     = out_free;
      default:   ;
    endcase
  end

  // Stage 1: compare the slot just read
  assign p1_key_hit = (key_r != '0) && (rd_rec.key == key_r);
  assign p1_expired = rd_rec.expiry < now_r;
  assign p1_live    = !p1_expired && (rd_rec.radius != '0);

  // Stage 2: round the loss and saturate the radius at zero
  assign loss_sum   = {1'b0, p2_prod_r} + (2*DELTA_W+1)'(32768);
  assign loss       = loss_sum[2*DELTA_W:DELTA_W];
  assign radius_dec = (loss >= {1'b0, p2_rec_r.radius}) ? '0
                    : p2_rec_r.radius - loss[RAD_W-1:0];
  assign tick_wr    = p2_v_r && p2_live_r;

  // Allocation choice: key match first, then first expired, else slot 0
  always_comb begin
    if (found_key_r) begin
      pick_idx = key_idx_r;
      pick_how = HOW_KEY;
    end else if (found_exp_r) begin
      pick_idx = exp_idx_r;
      pick_how = HOW_EXPIRED;
    end else begin
      pick_idx = '0;
      pick_how = HOW_FORCED;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p2_idx_r;
    wr_rec  = p2_rec_r;
    wr_rec.radius = radius_dec;
    if (tick_wr) begin
      wr_en = 1'b1;
    end else if (finish_go && act_r == ACT_ALLOC) begin
      wr_en   = 1'b1;
      wr_addr = pick_idx;
      wr_rec  = new_rec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      found_key_r <= 1'b0;
      found_exp_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= rd_en;
      p2_v_r  <= p1_v_r && (act_r == ACT_TICK);

      if (in_xfer) begin
        rd_idx_r    <= '0;
        found_key_r <= 1'b0;
        found_exp_r <= 1'b0;
      end else if (rd_en) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end

      // Keep the lowest index of each kind
      if (p1_v_r && act_r == ACT_ALLOC) begin
        if (p1_key_hit && !found_key_r) found_key_r <= 1'b1;
        if (p1_expired && !found_exp_r) found_exp_r <= 1'b1;
      end

      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r            <= in_chan.action;
      key_r            <= in_chan.light_key;
      now_r            <= in_chan.now;
      elapsed_r        <= in_chan.elapsed;
      new_rec_r.key    <= in_chan.light_key;
      new_rec_r.expiry <= in_chan.new_expiry;
      new_rec_r.radius <= in_chan.new_radius;
      new_rec_r.decay  <= in_chan.new_decay;
    end
    if (rd_en) begin
      p1_idx_r <= rd_idx_r;
    end
    if (p1_v_r) begin
      p2_idx_r  <= p1_idx_r;
      p2_rec_r  <= rd_rec;
      p2_live_r <= p1_live;
      p2_prod_r <= {{DELTA_W{1'b0}}, elapsed_r} * {{(2*DELTA_W-DECAY_W){1'b0}}, rd_rec.decay};
      if (p1_key_hit && !found_key_r) key_idx_r <= p1_idx_r;
      if (p1_expired && !found_exp_r) exp_idx_r <= p1_idx_r;
    end
    if (finish_go) begin
      if (act_r == ACT_TICK) begin
        out_slot_r <= '0;
        out_how_r  <= HOW_TICK;
      end else begin
        out_slot_r <= SLOT_W'(pick_idx);
        out_how_r  <= pick_how;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.slot       = out_slot_r;
  assign out_chan.how_chosen = out_how_r;

`ifndef ASSERT_OFF
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish");

  a_pipe_empty_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> !p1_v_r && !p2_v_r)
    else $error("pipeline busy at finish");

  a_alloc_write_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && act_r == ACT_ALLOC) |-> state_r == ST_FINISH)
    else $error("allocate wrote table during scan");

  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_xfer) |-> state_r == ST_SCAN && rd_idx_r == '0)
    else $error("scan did not start at slot zero");

  a_tick_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_how_r == HOW_TICK) |-> out_slot_r == '0)
    else $error("tick result with nonzero slot");
`endif

endmodule
